/* rtl/pidq_pkg.sv */
// Package for the packed ID queue: sizes, operation codes and transaction structs.
package pidq_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 8;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int KIND_W  = 2;
    localparam int TID_W   = 8;
    localparam int RID_W   = 8;
    localparam int OCNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POP    = 2'd2,
        OP_CLEAR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [TID_W-1:0]  task_id;
    } in_item_t;

    typedef struct packed {
        logic [RID_W-1:0]  removed_id;
        logic              ok;
        logic              empty_res;
        logic [OCNT_W-1:0] count;
    } out_item_t;

endpackage

/* rtl/packed_id_queue_with_removal_unit.sv */
// Top level of the packed ID wait queue with insert, remove by value, pop and clear.
//
//  channel | ports                   | payload
//  --------+-------------------------+---------------------------------------
//  input   | s_valid s_ready s_data  | in_item_t  {kind, task_id}
//  result  | m_valid m_ready m_data  | out_item_t {removed_id, ok, empty_res, count}
//
// One transaction per cycle while the result is not stalled: an item waits in the
// input register, then the queue update and its result are computed from the entry
// registers and captured together; m_valid rises when that result is registered.
// aresetn (synchronous) empties the queue and drops any pending transaction.
// A stalled result holds the pass; the input register still takes one item meanwhile.
module packed_id_queue_with_removal_unit
    import pidq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic                in_valid_reg;
    in_item_t            in_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic [ID_BITS-1:0]  entries_reg [DEPTH];
    logic [ID_BITS-1:0]  entries_next [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                advance;
    logic [ID_BITS-1:0]  id;
    logic [DEPTH-1:0]    match;
    logic [DEPTH-1:0]    shift;
    logic [DEPTH-1:0]    first;
    logic [DEPTH-1:0]    ins_slot;
    logic [ID_BITS-1:0]  removed;
    logic                ok;
    out_item_t           res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign id      = ID_BITS'(in_reg.task_id);

    // match and gap-closing masks
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i]    = valid_reg[i] && (entries_reg[i] == id);
            ins_slot[i] = !valid_reg[i] && ((i == 0) || valid_reg[(i == 0) ? 0 : i - 1]);
        end
        shift[0] = match[0];
        first[0] = match[0];
        for (int i = 1; i < DEPTH; i++) begin
            shift[i] = shift[i-1] | match[i];
            first[i] = match[i] & !shift[i-1];
        end
    end

    always_comb begin
        logic [ID_BITS-1:0] hit_id;
        logic [DEPTH-1:0]   sh;
        hit_id = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_id = hit_id | (entries_reg[i] & {ID_BITS{first[i]}});
        end
        entries_next = entries_reg;
        valid_next   = valid_reg;
        count_next   = count_reg;
        removed      = '0;
        ok           = 1'b0;
        sh           = '0;
        case (in_reg.kind)
            OP_INSERT: begin
                if (!valid_reg[DEPTH-1]) begin
                    ok = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (ins_slot[i]) begin
                            entries_next[i] = id;
                            valid_next[i]   = 1'b1;
                        end
                    end
                end
            end
            OP_REMOVE: begin
                if (shift[DEPTH-1]) begin
                    ok      = 1'b1;
                    removed = hit_id;
                    sh      = shift;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_POP: begin
                if (valid_reg[0]) begin
                    ok      = 1'b1;
                    removed = entries_reg[0];
                    sh      = '1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                ok         = 1'b1;
                valid_next = '0;
                count_next = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        // close the gap: move later entries forward
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (sh[i]) begin
                entries_next[i] = entries_reg[i+1];
                valid_next[i]   = valid_reg[i+1];
            end
        end
        if (sh[DEPTH-1]) begin
            valid_next[DEPTH-1] = 1'b0;
        end
    end

    always_comb begin
        res.removed_id = RID_W'(removed);
        res.ok         = ok;
        res.empty_res  = (count_next == '0);
        res.count      = OCNT_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                valid_reg     <= valid_next;
                count_reg     <= count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg     <= res;
            entries_reg <= entries_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(count_reg))
        else $error("count disagrees with valid slots");

    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_reg + DEPTH'(1)) & valid_reg) == '0)
        else $error("valid slots are not packed from the head");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_reg.kind == OP_CLEAR) |=> (count_reg == '0) && m_valid)
        else $error("clear left entries behind");

    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid && (m_data.empty_res == (count_reg == '0)))
        else $error("result missing or empty flag wrong");
`endif

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the packed ID wait queue: directed table, then random traffic.
module tb_top;
    import pidq_pkg::*;

    typedef struct packed {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } table_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // Shadow copy of the queue, updated on every accepted input transaction
    logic [ID_BITS-1:0] shadow_ids [DEPTH];
    int                 shadow_count = 0;

    out_item_t  pending_results [$];
    table_row_t directed_rows [$];
    int         failures = 0;
    bit         calm = 1'b0;
    bit         hold_off_req = 1'b0;

    packed_id_queue_with_removal_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one operation to the shadow queue and return the result it produces
    function automatic out_item_t apply_queue_op(in_item_t op);
        out_item_t          res;
        int                 hit;
        logic [ID_BITS-1:0] id;
        res = '0;
        hit = -1;
        id  = op.task_id[ID_BITS-1:0];
        case (op.kind)
            OP_INSERT: begin
                if (shadow_count < DEPTH) begin
                    shadow_ids[shadow_count] = id;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < shadow_count; i++)
                    if (hit < 0 && shadow_ids[i] == id) hit = i;
            end
            OP_POP: begin
                if (shadow_count > 0) hit = 0;
            end
            OP_CLEAR: begin
                shadow_count = 0;
                res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        // Close the gap left by a remove or pop
        if (hit >= 0) begin
            res.removed_id = RID_W'(shadow_ids[hit]);
            res.ok = 1'b1;
            for (int i = hit; i < shadow_count - 1; i++)
                shadow_ids[i] = shadow_ids[i + 1];
            shadow_count--;
        end
        res.empty_res = (shadow_count == 0);
        res.count     = OCNT_W'(shadow_count);
        return res;
    endfunction

    function automatic void add_row(kind_t k, logic [TID_W-1:0] id, bit typed = 1'b0,
                                    logic [RID_W-1:0] rid = '0, bit okv = 1'b0,
                                    bit emp = 1'b0, logic [OCNT_W-1:0] cnt = '0);
        table_row_t row;
        row.stim.kind       = k;
        row.stim.task_id    = id;
        row.typed           = typed;
        row.want.removed_id = rid;
        row.want.ok         = okv;
        row.want.empty_res  = emp;
        row.want.count      = cnt;
        directed_rows.push_back(row);
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic offer(input in_item_t op, input bit typed, input out_item_t typed_res);
        out_item_t predicted;
        if (!calm && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_queue_op(op);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge aclk);
    endtask

    // Result side: random stalls, a quiet window, and one long hold-off on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (80) @(negedge aclk);
            end else if (!calm && $urandom_range(99) < 11) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    out_item_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing pending: %h", m_data);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.removed_id !== want.removed_id) begin
                    $error("removed_id: expected %0d, got %0d", want.removed_id,
                           m_data.removed_id);
                    failures++;
                end
                if (m_data.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, m_data.ok);
                    failures++;
                end
                if (m_data.empty_res !== want.empty_res) begin
                    $error("empty_res: expected %0d, got %0d", want.empty_res,
                           m_data.empty_res);
                    failures++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_data.count);
                    failures++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        in_item_t op;
        int       fill_left;
        int       pick;
        s_valid = 1'b0;
        s_data  = '0;
        fill_left = 0;

        // Empty list, fill to full, overflow, removals, clears
        add_row(OP_POP,    8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 5'd0);
        add_row(OP_REMOVE, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 5'd0);
        add_row(OP_INSERT, 8'hFF, 1'b1, 8'h00, 1'b1, 1'b0, 5'd1);
        add_row(OP_INSERT, 8'h00);
        add_row(OP_INSERT, 8'h01);
        add_row(OP_INSERT, 8'h02);
        add_row(OP_INSERT, 8'h04);
        add_row(OP_INSERT, 8'h08);
        add_row(OP_INSERT, 8'h10);
        add_row(OP_INSERT, 8'h20);
        add_row(OP_INSERT, 8'h40);
        add_row(OP_INSERT, 8'h80);
        add_row(OP_INSERT, 8'h7F);
        add_row(OP_INSERT, 8'hBF);
        add_row(OP_INSERT, 8'hDF);
        add_row(OP_INSERT, 8'hEF);
        add_row(OP_INSERT, 8'hF7);
        add_row(OP_INSERT, 8'hFB, 1'b1, 8'h00, 1'b1, 1'b0, 5'd16);
        add_row(OP_INSERT, 8'h42, 1'b1, 8'h00, 1'b0, 1'b0, 5'd16);
        add_row(OP_REMOVE, 8'h10);
        add_row(OP_REMOVE, 8'h99, 1'b1, 8'h00, 1'b0, 1'b0, 5'd15);
        add_row(OP_POP,    8'h5A);
        add_row(OP_CLEAR,  8'hA5, 1'b1, 8'h00, 1'b1, 1'b1, 5'd0);
        add_row(OP_CLEAR,  8'h3C, 1'b1, 8'h00, 1'b1, 1'b1, 5'd0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            offer(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < 1330; n++) begin
            calm = (n >= 400 && n < 600);
            if (n == 800) hold_off_req = 1'b1;
            if (n == 1000) begin
                // Stop offering and let the queue drain completely
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(negedge aclk);
            end
            // Insert bursts push the list to full and past it
            if (n % 150 == 75) fill_left = 18 + $urandom_range(0, 4);

            pick = $urandom_range(99);
            if (fill_left > 0) begin
                op.kind = OP_INSERT;
                fill_left--;
            end else if (pick < 48) op.kind = OP_INSERT;
            else if (pick < 72) op.kind = OP_REMOVE;
            else if (pick < 92) op.kind = OP_POP;
            else if (pick < 95) op.kind = OP_CLEAR;
            else op.kind = kind_t'($urandom_range(3));

            if (op.kind == OP_REMOVE && shadow_count > 0 && $urandom_range(99) < 70)
                op.task_id = TID_W'(shadow_ids[$urandom_range(shadow_count - 1)]);
            else if ($urandom_range(1))
                op.task_id = TID_W'($urandom_range(7));
            else
                op.task_id = TID_W'($urandom_range(255));

            offer(op, 1'b0, '0);
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pidq_pkg.sv
rtl/packed_id_queue_with_removal_unit.sv
verif/tb_top.sv
